### design/des_pkg.sv
// Package with types, constants and helpers for the differential evolution step unit.
package des_pkg;

    localparam int PopSize   = 16;
    localparam int VectorLen = 16;
    localparam int IndW      = $clog2(PopSize);
    localparam int VarW      = $clog2(VectorLen);
    localparam int AddrW     = IndW + 1 + VarW;

    localparam logic [15:0] MutationScaleReset = 16'd26214;
    localparam logic [16:0] CrossoverReset     = 17'd6554;
    localparam logic signed [63:0] CostMax = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] CostMin = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_TRIAL  = 2'd1,
        OP_SELECT = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        CFG_MUTATION_SCALE = 1'b0,
        CFG_CROSSOVER      = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         individual;
        logic [3:0]         variable;
        logic [3:0]         base_index;
        logic [3:0]         diff_first;
        logic [3:0]         diff_second;
        logic [15:0]        rand_fraction;
        logic               forced;
        logic signed [31:0] load_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] data_value;
        logic signed [63:0] item_cost;
        logic signed [63:0] best_cost;
        logic [3:0]         best_index;
        logic               improved;
        logic               replaced;
    } out_word_t;

    // Request from the sequencer to the shared multiply unit.
    typedef struct packed {
        logic               start;
        logic               square;
        logic signed [32:0] a;
        logic [16:0]        b;
    } mul_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

### design/des_mul.sv
// Shared registered multiplier used for the mutation product and the element square.
module des_mul (
    input  logic                 clk,
    input  des_pkg::mul_req_t    req,
    input  logic signed [31:0]   sq_in,
    output logic signed [63:0]   prod
);
    import des_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [63:0] prod_next;

    // One multiply a cycle while start is set: a signed 33-bit by unsigned 17-bit product or a signed 32x32 square.
    always_comb
    begin
        if (req.square)
        begin
            prod_next = 64'(sq_in) * 64'(sq_in);
        end
        else
        begin
            prod_next = 64'(req.a) * 64'($signed({1'b0, req.b}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;
endmodule

### design/differential_evolution_step_unit.sv
// Top level: sequencer, population memory, cost registers and the shared multiplier.
// Throughput: one item at a time; the sequencer issues one population memory read a cycle
// and feeds the single multiplier, so a trial item needs four reads and two products.
// The output register frees the sequencer once the result word is taken.
// Reset: rst_n is asynchronous, active low; it clears active banks, the accumulator and the
// best record and restores the configuration registers; the population memory is not cleared.
module differential_evolution_step_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  des_pkg::in_word_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output des_pkg::out_word_t   out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [0:0]           cfg_index,
    input  logic [16:0]          cfg_data
);
    import des_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RD1   = 8'b0000_0010,
        ST_RD2   = 8'b0000_0100,
        ST_RD3   = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_SQ    = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] mscale_reg;
    logic [16:0] xthr_reg;

    in_word_t item_reg;
    logic [PopSize-1:0] bank_reg;
    logic signed [63:0] pcost_reg [PopSize];
    logic signed [63:0] tcost_reg [PopSize];
    logic signed [63:0] acc_reg;
    logic signed [63:0] best_reg;
    logic [IndW-1:0] besti_reg;

    logic [31:0] mem [2**AddrW];
    logic [AddrW-1:0] rd_addr;
    logic signed [31:0] rd_data;
    logic wr_en;
    logic [AddrW-1:0] wr_addr;
    logic signed [31:0] wr_data;

    logic signed [31:0] base_reg, first_reg, elem_reg;
    logic out_valid_reg;
    out_word_t out_reg;

    mul_req_t mreq;
    logic signed [63:0] prod;

    logic [IndW-1:0] ind, r1, r2, r3;
    logic [VarW-1:0] var_i;
    logic accept;

    assign ind   = item_reg.individual[IndW-1:0];
    assign r1    = item_reg.base_index[IndW-1:0];
    assign r2    = item_reg.diff_first[IndW-1:0];
    assign r3    = item_reg.diff_second[IndW-1:0];
    assign var_i = item_reg.variable[VarW-1:0];

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mscale_reg <= MutationScaleReset;
            xthr_reg   <= CrossoverReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MUTATION_SCALE: mscale_reg <= cfg_data[15:0];
                CFG_CROSSOVER:      xthr_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Population memory: one read and one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // Read address follows the sequencer step; a read item fetches its own element.
    always_comb
    begin
        rd_addr = {ind, bank_reg[ind], var_i};
        unique case (state_reg)
            ST_RD1:  rd_addr = {r1, bank_reg[r1], var_i};
            ST_RD2:  rd_addr = {r2, bank_reg[r2], var_i};
            ST_RD3:
            begin
                if (op_t'(item_reg.op) == OP_TRIAL)
                begin
                    rd_addr = {r3, bank_reg[r3], var_i};
                end
                else
                begin
                    rd_addr = {ind, bank_reg[ind], var_i};
                end
            end
            default: rd_addr = {ind, bank_reg[ind], var_i};
        endcase
    end

    // Trial element: mutant from the rounded product, then crossover with the parent,
    // which sits on the read port during the square step; the trial element is held afterwards.
    logic signed [63:0] rnd_t;
    logic signed [47:0] rnd_q;
    logic signed [31:0] mutant, trial_el, cur_el;
    logic take_mut;
    always_comb
    begin
        rnd_t    = prod + 64'sd32768;
        rnd_q    = rnd_t[63:16];
        mutant   = sat32(34'(base_reg) + 34'(rnd_q));
        take_mut = ({1'b0, item_reg.rand_fraction} < xthr_reg) || item_reg.forced;
        trial_el = take_mut ? mutant : rd_data;
        if (op_t'(item_reg.op) == OP_LOAD)
        begin
            cur_el = item_reg.load_value;
        end
        else if (state_reg == ST_SQ)
        begin
            cur_el = trial_el;
        end
        else
        begin
            cur_el = elem_reg;
        end
    end

    // Multiplier requests: difference times F, or the element square.
    always_comb
    begin
        mreq.start  = (state_reg == ST_MUL) || (state_reg == ST_SQ);
        mreq.square = (state_reg == ST_SQ);
        mreq.a      = 33'(first_reg) - 33'(rd_data);
        mreq.b      = {1'b0, mscale_reg};
    end

    des_mul u_mul (
        .clk   (clk),
        .req   (mreq),
        .sq_in (cur_el),
        .prod  (prod)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(in_data.op))
                        OP_TRIAL:  state_next = ST_RD1;
                        OP_SELECT: state_next = ST_DONE;
                        default:   state_next = ST_RD3;
                    endcase
                end
            end
            ST_RD1: state_next = ST_RD2;
            ST_RD2: state_next = ST_RD3;
            ST_RD3:
            begin
                unique case (op_t'(item_reg.op))
                    OP_TRIAL: state_next = ST_MUL;
                    OP_LOAD:  state_next = ST_SQ;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_MUL: state_next = ST_SQ;
            ST_SQ:  state_next = ST_ACC;
            ST_ACC: state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Saturating accumulate of the square: added for even variables, subtracted for odd ones.
    logic signed [63:0] acc_base, acc_sum, acc_new;
    logic signed [64:0] acc_wide;
    always_comb
    begin
        acc_base = (var_i == '0) ? 64'sd0 : acc_reg;
        if (var_i[0])
        begin
            acc_wide = 65'(acc_base) - 65'(prod);
        end
        else
        begin
            acc_wide = 65'(acc_base) + 65'(prod);
        end
        acc_sum = acc_wide[63:0];
        if (acc_wide > 65'(CostMax))
        begin
            acc_new = CostMax;
        end
        else if (acc_wide < 65'(CostMin))
        begin
            acc_new = CostMin;
        end
        else
        begin
            acc_new = acc_sum;
        end
    end

    logic is_last;
    assign is_last = (var_i == VarW'(VectorLen - 1));

    // A select item adopts the trial bank only when its cost is strictly lower.
    logic adopt;
    assign adopt = (op_t'(item_reg.op) == OP_SELECT) && (tcost_reg[ind] < pcost_reg[ind]);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {ind, bank_reg[ind], var_i};
        wr_data = cur_el;
        if (state_reg == ST_ACC)
        begin
            wr_en = 1'b1;
            if (op_t'(item_reg.op) == OP_TRIAL)
            begin
                wr_addr = {ind, ~bank_reg[ind], var_i};
            end
        end
    end

    // Control and cost state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bank_reg      <= '0;
            acc_reg       <= '0;
            best_reg      <= CostMax;
            besti_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_ACC)
            begin
                acc_reg <= acc_new;
                if (is_last && acc_new < best_reg)
                begin
                    best_reg  <= acc_new;
                    besti_reg <= ind;
                end
            end
            if (state_reg == ST_DONE && adopt)
            begin
                bank_reg[ind] <= ~bank_reg[ind];
            end
            if (state_reg == ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers and result word.
    logic impr_reg;
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            impr_reg <= 1'b0;
        end
        if (state_reg == ST_RD2)
        begin
            base_reg <= rd_data;
        end
        if (state_reg == ST_RD3)
        begin
            first_reg <= rd_data;
        end
        if (state_reg == ST_SQ)
        begin
            elem_reg <= trial_el;
        end
        if (state_reg == ST_ACC)
        begin
            impr_reg <= is_last && (acc_new < best_reg);
            if (is_last)
            begin
                if (op_t'(item_reg.op) == OP_TRIAL)
                begin
                    tcost_reg[ind] <= acc_new;
                end
                else
                begin
                    pcost_reg[ind] <= acc_new;
                end
            end
            out_reg.data_value <= cur_el;
        end
        if (state_reg == ST_DONE)
        begin
            out_reg.best_cost  <= best_reg;
            out_reg.best_index <= 4'(besti_reg);
            out_reg.improved   <= impr_reg;
            out_reg.replaced   <= adopt;
            unique case (op_t'(item_reg.op))
                OP_SELECT:
                begin
                    out_reg.data_value <= '0;
                    if (adopt)
                    begin
                        pcost_reg[ind]    <= tcost_reg[ind];
                        out_reg.item_cost <= tcost_reg[ind];
                    end
                    else
                    begin
                        out_reg.item_cost <= pcost_reg[ind];
                    end
                end
                OP_READ:
                begin
                    out_reg.data_value <= rd_data;
                    out_reg.item_cost  <= acc_reg;
                end
                default: out_reg.item_cost <= acc_reg;
            endcase
        end
    end

    // The result register is never overwritten while a word waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");
    // No item is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted with pending result");
    // Improvement only reported together with a matching best record.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && out_data.improved |-> out_data.best_cost == out_data.item_cost)
        else $error("improved without new best");
endmodule
